// ===== hdl/acc_pkg.sv =====
// shared types, constants and codes of the adaptive concurrency controller
package acc_pkg;

    // history of speed samples, newest first
    localparam int HIST_DEPTH = 8;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int WSUM_MAX   = HIST_DEPTH * (HIST_DEPTH + 1) / 2;
    localparam int WSUM_W     = $clog2(WSUM_MAX + 1);

    // field widths
    localparam int BYTES_W    = 32;
    localparam int MS_W       = 16;
    localparam int REQ_W      = 9;
    localparam int ACCEL_W    = 7;
    localparam int BPS_W      = 40;
    localparam int PHASE_W    = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // a sample is at most (2^32 - 1) * 1000 / 50, below 2^37
    localparam int SPEED_W    = 37;

    // sample arithmetic
    localparam int MS_PER_S   = 1000;
    localparam int MS_PER_S_W = 10;
    localparam int PROD_W     = BYTES_W + MS_PER_S_W;
    localparam int MIN_MS     = 50;

    // weighted history sum
    localparam int SUM_W      = SPEED_W + WSUM_W;

    // floor candidate is 85 / 100 of the weighted average
    localparam int FLOOR_NUM   = 85;
    localparam int FLOOR_NUM_W = 7;
    localparam int FLOOR_DEN   = 100;
    localparam int F85_W       = SPEED_W + FLOOR_NUM_W;

    // shared divider, two quotient bits per cycle
    localparam int DVD_RAW   = (PROD_W > SUM_W) ? ((PROD_W > F85_W) ? PROD_W : F85_W)
                                                : ((SUM_W > F85_W) ? SUM_W : F85_W);
    localparam int DVD_W     = ((DVD_RAW + 1) / 2) * 2;
    localparam int DVS_W     = MS_W;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // scheduling constants
    localparam int MAX_LO         = 16;
    localparam int MAX_HI         = 256;
    localparam int COOL_MIN       = 4;
    localparam int STEADY_RESTART = 8;

    // register reset values
    localparam int MAX_CONC_RST  = 64;
    localparam int BURST_RST     = 20;
    localparam int ACCEL_RST     = 8;
    localparam int MIN_FLOOR_RST = 262144;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd4;

    typedef enum logic [PHASE_W-1:0] {
        PH_BURST    = 2'd0,
        PH_ACCEL    = 2'd1,
        PH_STEADY   = 2'd2,
        PH_COOLDOWN = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_SAMPLE,
        S_WALK,
        S_DIV_WAVG,
        S_FLOOR_CHK,
        S_DIV_FLOOR,
        S_SCHED
    } t_state;

    typedef enum logic [1:0] {
        DSEL_SAMPLE,
        DSEL_WAVG,
        DSEL_FLOOR
    } t_div_sel;

    typedef struct packed {
        logic     latch;
        logic     walk_clear;
        logic     div_start;
        t_div_sel div_sel;
        logic     push;
        logic     walk_step;
        logic     wavg_load;
        logic     floor_upd;
        logic     sched;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic short_tick;
        logic div_done;
        logic walk_done;
        logic wsum_zero;
        logic wavg_low;
        logic out_busy;
    } t_status;

endpackage

// ===== hdl/acc_in_if.sv =====
// input channel: scheduling tick or start item
interface acc_in_if import acc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [BYTES_W-1:0] bytes_delta;
    logic [MS_W-1:0]    elapsed_ms;
    logic [REQ_W-1:0]   inflight_count;
    logic               work_pending;

    modport source (
        output valid, opcode, bytes_delta, elapsed_ms, inflight_count, work_pending,
        input  ready
    );
    modport sink (
        input  valid, opcode, bytes_delta, elapsed_ms, inflight_count, work_pending,
        output ready
    );
endinterface

// ===== hdl/acc_out_if.sv =====
// output channel: one scheduling result per item
interface acc_out_if import acc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   send_count;
    logic               stop_ticks;
    logic [REQ_W-1:0]   target_inflight;
    logic [PHASE_W-1:0] phase;

    modport source (
        output valid, send_count, stop_ticks, target_inflight, phase,
        input  ready
    );
    modport sink (
        input  valid, send_count, stop_ticks, target_inflight, phase,
        output ready
    );
endinterface

// ===== hdl/acc_div.sv =====
// shared restoring divider, two quotient bits per cycle
module acc_div import acc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic [DVD_W-1:0]  r_quo, n_quo;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    always_comb begin
        logic [DVS_W:0] sh;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            sh    = {n_rem, n_quo[DVD_W-1]};
            n_quo = {n_quo[DVD_W-2:0], 1'b0};
            if (sh >= {1'b0, r_dvs}) begin
                sh       = sh - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/acc_ctrl.sv =====
// sequencer of the controller: steps one item through sample, walk, floor and scheduling
module acc_ctrl import acc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.is_start)        n_state = S_SCHED;
                else if (i_status.short_tick) n_state = S_WALK;
                else                          n_state = S_DIV_SAMPLE;
            end
            S_DIV_SAMPLE: begin
                if (i_status.div_done) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = i_status.wsum_zero ? S_SCHED : S_DIV_WAVG;
                end
            end
            S_DIV_WAVG: begin
                if (i_status.div_done) n_state = S_FLOOR_CHK;
            end
            S_FLOOR_CHK: begin
                n_state = i_status.wavg_low ? S_SCHED : S_DIV_FLOOR;
            end
            S_DIV_FLOOR: begin
                if (i_status.div_done) n_state = S_SCHED;
            end
            S_SCHED: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = DSEL_SAMPLE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.walk_clear = 1'b1;
                o_cmd.div_start  = !i_status.is_start && !i_status.short_tick;
                o_cmd.div_sel    = DSEL_SAMPLE;
            end
            S_DIV_SAMPLE: begin
                o_cmd.push = i_status.div_done;
            end
            S_WALK: begin
                o_cmd.walk_step = !i_status.walk_done;
                o_cmd.div_start = i_status.walk_done && !i_status.wsum_zero;
                o_cmd.div_sel   = DSEL_WAVG;
            end
            S_DIV_WAVG: begin
                o_cmd.wavg_load = i_status.div_done;
            end
            S_FLOOR_CHK: begin
                o_cmd.div_start = !i_status.wavg_low;
                o_cmd.div_sel   = DSEL_FLOOR;
            end
            S_DIV_FLOOR: begin
                o_cmd.floor_upd = i_status.div_done;
            end
            S_SCHED: begin
                o_cmd.sched = !i_status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/acc_datapath.sv =====
// datapath: registers, speed history, divider feed, scheduling rules and result register
module acc_datapath import acc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_opcode,
    input  logic [BYTES_W-1:0]    i_bytes_delta,
    input  logic [MS_W-1:0]       i_elapsed_ms,
    input  logic [REQ_W-1:0]      i_inflight_count,
    input  logic                  i_work_pending,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [REQ_W-1:0]      o_send_count,
    output logic                  o_stop_ticks,
    output logic [REQ_W-1:0]      o_target_inflight,
    output logic [PHASE_W-1:0]    o_phase
);

    // configuration
    logic [REQ_W-1:0]   r_max_conc;
    logic [REQ_W-1:0]   r_burst;
    logic [ACCEL_W-1:0] r_accel;
    logic [BPS_W-1:0]   r_min_floor;
    logic [BPS_W-1:0]   r_speed_limit;

    // latched item
    logic               r_op;
    logic [BYTES_W-1:0] r_bytes;
    logic [MS_W-1:0]    r_ms;
    logic [REQ_W-1:0]   r_inflight;
    logic               r_pending;

    // controller state
    t_phase             r_phase;
    logic [REQ_W-1:0]   r_target;
    logic [SPEED_W-1:0] r_hist [HIST_DEPTH];
    logic [CNT_W-1:0]   r_hcount;
    logic [SPEED_W-1:0] r_floor;
    logic [SPEED_W-1:0] r_avg;

    // history walk
    logic [CNT_W-1:0]   r_widx;
    logic [SUM_W-1:0]   r_wacc;
    logic [WSUM_W-1:0]  r_wsum;
    logic [SPEED_W-1:0] r_wavg;

    // result register
    logic               r_out_valid;
    logic [REQ_W-1:0]   r_out_send;
    logic               r_out_stop;
    logic [REQ_W-1:0]   r_out_target;
    t_phase             r_out_phase;

    // divider
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [SPEED_W-1:0] q_speed;

    acc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign q_speed = div_q[SPEED_W-1:0];

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_SAMPLE: begin
                dvd = DVD_W'(PROD_W'(r_bytes) * PROD_W'(MS_PER_S));
                dvs = r_ms;
            end
            DSEL_WAVG: begin
                dvd = DVD_W'(r_wacc);
                dvs = DVS_W'(r_wsum);
            end
            DSEL_FLOOR: begin
                dvd = DVD_W'(F85_W'(r_wavg) * F85_W'(FLOOR_NUM));
                dvs = DVS_W'(FLOOR_DEN);
            end
            default: begin
                dvd = '0;
                dvs = DVS_W'(FLOOR_DEN);
            end
        endcase
    end

    // walk term of the current entry, weight falls from count to one
    logic [CNT_W-1:0]   weight;
    logic [SPEED_W-1:0] walk_entry;

    assign weight     = r_hcount - r_widx;
    assign walk_entry = r_hist[r_widx[HIDX_W-1:0]];

    // scheduling
    logic [REQ_W-1:0]   mx;
    logic [SPEED_W-1:0] speed;
    logic [REQ_W:0]     mx_x;
    logic [REQ_W:0]     inf_x;
    logic [REQ_W:0]     inf_acc;
    logic [REQ_W:0]     inf_acc_cl;
    logic [REQ_W:0]     burst_acc;
    logic [REQ_W:0]     t;
    t_phase             n_phase;
    logic [REQ_W-1:0]   n_target;
    logic [REQ_W-1:0]   n_send;
    logic               n_stop;
    logic               gate;
    logic [REQ_W-1:0]   start_send;
    logic [REQ_W-1:0]   gap;

    always_comb begin
        if (r_max_conc < REQ_W'(MAX_LO))      mx = REQ_W'(MAX_LO);
        else if (r_max_conc > REQ_W'(MAX_HI)) mx = REQ_W'(MAX_HI);
        else                                  mx = r_max_conc;

        speed      = (r_hcount != '0) ? r_hist[0] : '0;
        mx_x       = (REQ_W+1)'(mx);
        inf_x      = (REQ_W+1)'(r_inflight);
        inf_acc    = inf_x + (REQ_W+1)'(r_accel);
        inf_acc_cl = (inf_acc < mx_x) ? inf_acc : mx_x;
        burst_acc  = (REQ_W+1)'(r_burst) + (REQ_W+1)'(r_accel);

        n_phase = r_phase;
        t       = (REQ_W+1)'(r_target);
        unique case (r_phase)
            PH_BURST: begin
                n_phase = PH_ACCEL;
                t       = (burst_acc < mx_x) ? burst_acc : mx_x;
            end
            PH_ACCEL: begin
                if (r_inflight >= mx || !r_pending) begin
                    n_phase = PH_STEADY;
                    t       = mx_x;
                end else if (speed >= r_floor) begin
                    n_phase = PH_STEADY;
                    t       = inf_x;
                end else begin
                    t = inf_acc_cl;
                end
            end
            PH_STEADY: begin
                if (!r_pending) begin
                    t = inf_x;
                end else if (speed < r_floor && r_inflight < mx) begin
                    n_phase = PH_ACCEL;
                    t       = inf_acc_cl;
                end else if (speed == '0 && r_inflight >= REQ_W'(COOL_MIN)) begin
                    n_phase = PH_COOLDOWN;
                    t       = ((inf_x >> 1) > (REQ_W+1)'(COOL_MIN)) ? (inf_x >> 1)
                                                                    : (REQ_W+1)'(COOL_MIN);
                end else begin
                    t = ((inf_x + 1'b1) < mx_x) ? (inf_x + 1'b1) : mx_x;
                end
            end
            PH_COOLDOWN: begin
                if (speed != '0) begin
                    n_phase = PH_ACCEL;
                    t       = inf_acc_cl;
                end else if (r_inflight <= REQ_W'(COOL_MIN) || !r_pending) begin
                    n_phase = PH_STEADY;
                    t       = ((REQ_W+1)'(STEADY_RESTART) < mx_x) ?
                              (REQ_W+1)'(STEADY_RESTART) : mx_x;
                end
            end
            default: ;
        endcase
        n_target = (t > (REQ_W+1)'(MAX_HI)) ? REQ_W'(MAX_HI) : t[REQ_W-1:0];

        gap    = n_target - r_inflight;
        n_send = '0;
        n_stop = 1'b0;
        if (r_inflight >= n_target || !r_pending) begin
            n_stop = (r_inflight >= mx) || !r_pending;
        end else begin
            n_send = (gap < REQ_W'(r_accel)) ? gap : REQ_W'(r_accel);
        end

        gate       = (r_speed_limit != '0) && (BPS_W'(r_avg) >= r_speed_limit);
        start_send = (r_burst < mx) ? r_burst : mx;
    end

    assign o_status.is_start   = r_op;
    assign o_status.short_tick = r_ms < MS_W'(MIN_MS);
    assign o_status.div_done   = div_done;
    assign o_status.walk_done  = r_widx == r_hcount;
    assign o_status.wsum_zero  = r_wsum == '0;
    assign o_status.wavg_low   = BPS_W'(r_wavg) < r_min_floor;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_conc    <= REQ_W'(MAX_CONC_RST);
            r_burst       <= REQ_W'(BURST_RST);
            r_accel       <= ACCEL_W'(ACCEL_RST);
            r_min_floor   <= BPS_W'(MIN_FLOOR_RST);
            r_speed_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_CONC:    r_max_conc    <= i_cfg_data[REQ_W-1:0];
                CFG_BURST:       r_burst       <= i_cfg_data[REQ_W-1:0];
                CFG_ACCEL:       r_accel       <= i_cfg_data[ACCEL_W-1:0];
                CFG_MIN_FLOOR:   r_min_floor   <= i_cfg_data[BPS_W-1:0];
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[BPS_W-1:0];
                default: ;
            endcase
        end
    end

    // item latch, history shift line and walk accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_opcode;
            r_bytes    <= i_bytes_delta;
            r_ms       <= i_elapsed_ms;
            r_inflight <= i_inflight_count;
            r_pending  <= i_work_pending;
        end
        if (i_cmd.push) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= q_speed;
        end
        if (i_cmd.walk_clear) begin
            r_wacc <= '0;
            r_wsum <= '0;
            r_widx <= '0;
        end else if (i_cmd.walk_step) begin
            r_wacc <= r_wacc + SUM_W'(walk_entry) * SUM_W'(weight);
            r_wsum <= r_wsum + WSUM_W'(weight);
            r_widx <= r_widx + 1'b1;
        end
        if (i_cmd.wavg_load) begin
            r_wavg <= q_speed;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BURST;
            r_target <= '0;
            r_hcount <= '0;
            r_floor  <= SPEED_W'(MIN_FLOOR_RST);
            r_avg    <= '0;
        end else begin
            if (i_cmd.push) begin
                if (r_hcount < CNT_W'(HIST_DEPTH)) r_hcount <= r_hcount + 1'b1;
                r_avg <= SPEED_W'(((SPEED_W+1)'(r_avg) + (SPEED_W+1)'(q_speed)) >> 1);
            end
            if (i_cmd.floor_upd && q_speed > r_floor) begin
                r_floor <= q_speed;
            end
            if (i_cmd.sched) begin
                if (r_op) begin
                    r_phase  <= PH_BURST;
                    r_target <= '0;
                end else if (!gate) begin
                    r_phase  <= n_phase;
                    r_target <= n_target;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.sched) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sched) begin
            if (r_op) begin
                r_out_send   <= start_send;
                r_out_stop   <= !r_pending ||
                                ((REQ_W+1)'(r_inflight) + (REQ_W+1)'(start_send) >= mx_x);
                r_out_target <= '0;
                r_out_phase  <= PH_BURST;
            end else if (gate) begin
                r_out_send   <= '0;
                r_out_stop   <= 1'b0;
                r_out_target <= r_target;
                r_out_phase  <= r_phase;
            end else begin
                r_out_send   <= n_send;
                r_out_stop   <= n_stop;
                r_out_target <= n_target;
                r_out_phase  <= n_phase;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_send_count      = r_out_send;
    assign o_stop_ticks      = r_out_stop;
    assign o_target_inflight = r_out_target;
    assign o_phase           = r_out_phase;

endmodule

// ===== hdl/adaptive_concurrency_controller.sv =====
// top level of the adaptive concurrency controller
//
// One result per item. A start item goes from its transfer to its result through accept,
// decode and schedule; schedule holds while the previous result is not yet taken. A tick
// with at least 50 ms elapsed also passes through the divider and the history walk: the
// shared divider produces two quotient bits a cycle and runs three divisions in series
// (bytes * 1000 / elapsed_ms, weighted history sum / weight sum, average * 85 / 100), and
// the history walk adds one entry a cycle. A short tick skips the sample division; the
// last two divisions drop out when the history is empty, and the floor division alone when
// the weighted average is below min_floor_bps. A new item is taken once the sequencer is
// back in idle, even while the previous result still waits in the output register.
// Configuration writes go straight to the registers and belong to idle periods only.
module adaptive_concurrency_controller import acc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    acc_in_if.sink                i_in,
    acc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer owns the input handshake
    acc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // datapath owns state, registers and the output register
    acc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_in.opcode),
        .i_bytes_delta     (i_in.bytes_delta),
        .i_elapsed_ms      (i_in.elapsed_ms),
        .i_inflight_count  (i_in.inflight_count),
        .i_work_pending    (i_in.work_pending),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_send_count      (o_out.send_count),
        .o_stop_ticks      (o_out.stop_ticks),
        .o_target_inflight (o_out.target_inflight),
        .o_phase           (o_out.phase)
    );

endmodule
